/* hdl/swt_pkg.sv */
// Shared types, codes and helpers for the shell word tokenizer.
// No dependencies; every other file of the block but swt_if imports this package.
`default_nettype none

package swt_pkg;

  // Argument limit: a byte that would start argument MAX_ARGS is an error.
  localparam int MAX_ARGS = 32;
  localparam int CNT_W    = $clog2(MAX_ARGS);
  localparam int MAX_RES  = 3;
  localparam int RES_W    = $clog2(MAX_RES + 1);

  // Scan modes
  localparam logic [1:0] MODE_GAP  = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_SQ   = 2'd2;
  localparam logic [1:0] MODE_DQ   = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5c;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_done;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
  } res_t;

  // All results caused by one item, first result in r[0].
  typedef struct packed {
    logic [RES_W-1:0]       n;
    res_t [MAX_RES-1:0]     r;
    logic [4:0]             word_count;
  } bundle_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  // Low five bits of the argument count.
  function automatic logic [4:0] count5(input logic [CNT_W-1:0] w);
    logic [63:0] wide;
    wide = 64'(w);
    return wide[4:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/swt_if.sv */
// Valid/ready channel interfaces for the shell word tokenizer.
// Text bytes come in on swt_text_if, tokens leave on swt_token_if.
`default_nettype none

interface swt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_done;

  modport source (output valid, output text_byte, output line_done, input ready);
  modport sink   (input valid, input text_byte, input line_done, output ready);
endinterface

interface swt_token_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [4:0] word_count;
  logic       last;

  modport source (output valid, output kind, output out_byte, output word_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input word_count,
                  input last, output ready);
endinterface

`default_nettype wire

/* hdl/swt_parse.sv */
// Scan state and per-byte decode of the shell word tokenizer.
// Depends on swt_pkg; turns one item into a bundle of up to three results.
`default_nettype none

module swt_parse (
  input  logic            clk,
  input  logic            rst,
  input  swt_pkg::item_t  item,
  input  logic            adv,
  output swt_pkg::bundle_t bundle
);
  import swt_pkg::*;

  logic [1:0]       scan_mode, scan_mode_next;
  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] words_seen, words_seen_next;
  logic             skip_to_end, skip_to_end_next;

  logic [RES_W-1:0] n;
  res_t [MAX_RES-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       mode_eff;
  logic             esc_eff;
  logic             go;
  logic             handled;
  logic [7:0]       c;

  always_comb begin
    c                   = item.text_byte;
    scan_mode_next      = scan_mode;
    escape_pending_next = escape_pending;
    words_seen_next     = words_seen;
    skip_to_end_next    = skip_to_end;
    n                   = '0;
    r                   = '0;
    cnt                 = words_seen;
    mode_eff            = scan_mode;
    esc_eff             = escape_pending;
    go                  = 1'b0;
    handled             = 1'b0;

    if (item.line_done) begin
      if (skip_to_end) begin
        // error already reported: drop
      end else if (scan_mode == MODE_SQ || scan_mode == MODE_DQ) begin
        r[n].kind = KIND_ERR;
        n = n + 1'b1;
      end else begin
        if (scan_mode == MODE_WORD) begin
          if (escape_pending) begin
            r[n].kind     = KIND_BYTE;
            r[n].out_byte = CH_BSL;
            n = n + 1'b1;
          end
          r[n].kind = KIND_END;
          n = n + 1'b1;
        end
        r[n].kind = KIND_LINE;
        n = n + 1'b1;
      end
      scan_mode_next      = MODE_GAP;
      escape_pending_next = 1'b0;
      words_seen_next     = '0;
      skip_to_end_next    = 1'b0;
    end else if (!skip_to_end) begin
      go = 1'b1;
      if (scan_mode == MODE_GAP) begin
        if (is_sep(c)) begin
          go = 1'b0;
        end else if (words_seen >= CNT_W'(MAX_ARGS - 1)) begin
          r[n].kind = KIND_ERR;
          n = n + 1'b1;
          skip_to_end_next = 1'b1;
          go = 1'b0;
        end else begin
          words_seen_next = words_seen + 1'b1;
          cnt             = words_seen + 1'b1;
          mode_eff        = MODE_WORD;
          esc_eff         = 1'b0;
        end
      end
      if (go) begin
        scan_mode_next      = mode_eff;
        escape_pending_next = esc_eff;
        case (mode_eff)
          MODE_WORD: begin
            if (esc_eff) begin
              escape_pending_next = 1'b0;
              r[n].kind = KIND_BYTE; r[n].out_byte = c; n = n + 1'b1;
            end else if (c == CH_SQ) begin
              scan_mode_next = MODE_SQ;
            end else if (c == CH_DQ) begin
              scan_mode_next = MODE_DQ;
            end else if (is_sep(c)) begin
              r[n].kind = KIND_END; n = n + 1'b1;
              scan_mode_next = MODE_GAP;
            end else if (c == CH_BSL) begin
              escape_pending_next = 1'b1;
            end else begin
              r[n].kind = KIND_BYTE; r[n].out_byte = c; n = n + 1'b1;
            end
          end
          MODE_SQ: begin
            if (c == CH_SQ) begin
              scan_mode_next = MODE_WORD;
            end else begin
              r[n].kind = KIND_BYTE; r[n].out_byte = c; n = n + 1'b1;
            end
          end
          MODE_DQ: begin
            if (esc_eff) begin
              escape_pending_next = 1'b0;
              if (c == CH_DQ || c == CH_BSL) begin
                r[n].kind = KIND_BYTE; r[n].out_byte = c; n = n + 1'b1;
                handled = 1'b1;
              end else begin
                // backslash escapes nothing here: keep it
                r[n].kind = KIND_BYTE; r[n].out_byte = CH_BSL; n = n + 1'b1;
              end
            end
            if (!handled) begin
              if (c == CH_DQ) begin
                scan_mode_next = MODE_WORD;
              end else if (c == CH_BSL) begin
                escape_pending_next = 1'b1;
              end else begin
                r[n].kind = KIND_BYTE; r[n].out_byte = c; n = n + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    bundle.n          = n;
    bundle.r          = r;
    bundle.word_count = count5(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_GAP;
      escape_pending <= 1'b0;
      words_seen     <= '0;
      skip_to_end    <= 1'b0;
    end else if (adv) begin
      scan_mode      <= scan_mode_next;
      escape_pending <= escape_pending_next;
      words_seen     <= words_seen_next;
      skip_to_end    <= skip_to_end_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/swt_outq.sv */
// Result register of the shell word tokenizer: holds one item's bundle and
// hands its results out one per accepted handshake. Depends on swt_pkg.
`default_nettype none

module swt_outq (
  input  logic             clk,
  input  logic             rst,
  input  swt_pkg::bundle_t bundle,
  input  logic             load,
  output logic             can_load,
  swt_token_if.source      token_ch
);
  import swt_pkg::*;

  logic [RES_W-1:0]   n;
  res_t [MAX_RES-1:0] e;
  logic [4:0]         cnt;
  logic               take;

  assign take     = token_ch.valid && token_ch.ready;
  assign can_load = (n == '0) || ((n == RES_W'(1)) && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (load) begin
      n <= bundle.n;
    end else if (take) begin
      n <= n - 1'b1;
    end
  end

  // Shift the remaining results towards slot zero.
  always_ff @(posedge clk) begin
    if (load) begin
      e   <= bundle.r;
      cnt <= bundle.word_count;
    end else if (take) begin
      e[0] <= e[1];
      e[1] <= e[2];
    end
  end

  assign token_ch.valid      = (n != '0);
  assign token_ch.kind       = e[0].kind;
  assign token_ch.out_byte   = e[0].out_byte;
  assign token_ch.word_count = cnt;
  assign token_ch.last       = (e[0].kind == KIND_LINE) || (e[0].kind == KIND_ERR);

endmodule

`default_nettype wire

/* hdl/shell_word_tokenizer.sv */
// Shell word tokenizer: splits a byte stream of command lines into arguments.
// Depends on swt_pkg, swt_if, swt_parse and swt_outq.
//
// Usage
//   text_ch carries one item per handshake: a text byte, or line_done to
//   close the line. token_ch returns argument bytes, end-of-argument marks,
//   and one line-finished (or parse error) result with last set per line.
//   Separators are space, tab and newline; single and double quotes group
//   text, and a backslash escapes as a small shell does.
// Timing
//   An accepted item sits in the input register, is decoded in a single
//   pass and is registered into the result register once that has room;
//   its first result is then offered on token_ch, straight from the result
//   register. One item is taken per cycle while results flow one per cycle
//   and each item causes at most one result; an item that causes two or
//   three results holds the input register until all but its last result
//   are taken, so the output handshake sets the sustained rate.
// Reset
//   rst (synchronous) returns the scanner to the between-words state with a
//   zero count and empties both registers.
// Stalls
//   While token_ch is held off, the result register holds its results and
//   the input register still takes one more item; text_ch.ready drops only
//   when both are full.
`default_nettype none

module shell_word_tokenizer (
  input  logic       clk,
  input  logic       rst,
  swt_text_if.sink   text_ch,
  swt_token_if.source token_ch
);
  import swt_pkg::*;

  logic             a_valid;
  item_t            a_item;
  logic             can_load;
  logic             adv;
  bundle_t          bundle;

  // Advance the held item into the result register when it has room.
  assign adv           = a_valid && can_load;
  assign text_ch.ready = !a_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (text_ch.valid && text_ch.ready) begin
      a_valid <= 1'b1;
    end else if (adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_ch.valid && text_ch.ready) begin
      a_item.text_byte <= text_ch.text_byte;
      a_item.line_done <= text_ch.line_done;
    end
  end

  swt_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .item   (a_item),
    .adv    (adv),
    .bundle (bundle)
  );

  swt_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .bundle   (bundle),
    .load     (adv),
    .can_load (can_load),
    .token_ch (token_ch)
  );

  // A held item that cannot advance stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !can_load |=> a_valid && $stable(a_item))
    else $error("input register lost or changed a stalled item");

  // Only argument bytes carry a character.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    token_ch.valid && token_ch.kind != KIND_BYTE |-> token_ch.out_byte == 8'd0)
    else $error("non-byte result carries a character");

  // Nothing is offered straight after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !token_ch.valid && !a_valid)
    else $error("result offered after reset");

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    token_ch.valid && !token_ch.ready |=> token_ch.valid && $stable(token_ch.kind)
      && $stable(token_ch.out_byte))
    else $error("stalled result changed");

endmodule

`default_nettype wire

/* verif/shell_word_tokenizer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for shell_word_tokenizer: directed and random command lines in, token stream checked.
// Depends on swt_pkg and the swt_text_if / swt_token_if channel interfaces.

module shell_word_tokenizer_tb;
  import swt_pkg::*;

  // Tracks the tokenizer's scan state and holds the tokens that are still due.
  class token_tracker;
    typedef struct {
      logic [1:0] kind;
      logic [7:0] ch;
      logic [4:0] count;
      logic       last;
    } token_t;

    token_t      tokens_due[$];
    logic [1:0]  mode;
    bit          esc;
    int unsigned words;
    bit          discard;
    int unsigned fails, matched, lines, parse_errs, args_closed;

    function new();
      restart();
    endfunction

    function void restart();
      mode    = MODE_GAP;
      esc     = 1'b0;
      words   = 0;
      discard = 1'b0;
    endfunction

    function bit is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NL;
    endfunction

    function void due(input logic [1:0] k, input logic [7:0] c, input logic lst);
      token_t t;
      t.kind  = k;
      t.ch    = (k == KIND_BYTE) ? c : 8'h00;
      t.count = 5'(words);
      t.last  = lst;
      tokens_due.push_back(t);
      if (k == KIND_ERR) parse_errs++;
      if (k == KIND_END) args_closed++;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    // Work out the tokens of one accepted item; returns 0 when the item changes nothing.
    function bit absorb_item(input logic [7:0] c, input logic done);
      if (done) begin
        lines++;
        if (!discard) begin
          if (mode == MODE_SQ || mode == MODE_DQ) begin
            due(KIND_ERR, 8'h00, 1'b1);
          end else begin
            if (mode == MODE_WORD) begin
              if (esc) due(KIND_BYTE, CH_BSL, 1'b0);
              due(KIND_END, 8'h00, 1'b0);
            end
            due(KIND_LINE, 8'h00, 1'b1);
          end
        end
        restart();
        return 1'b1;
      end
      if (discard) return 1'b0;
      if (mode == MODE_GAP) begin
        if (is_blank(c)) return 1'b0;
        if (words + 1 >= MAX_ARGS) begin
          due(KIND_ERR, 8'h00, 1'b1);
          discard = 1'b1;
          return 1'b1;
        end
        words++;
        mode = MODE_WORD;
        esc  = 1'b0;
      end
      case (mode)
        MODE_WORD: begin
          if (esc) begin
            esc = 1'b0;
            due(KIND_BYTE, c, 1'b0);
          end else if (c == CH_SQ) begin
            mode = MODE_SQ;
          end else if (c == CH_DQ) begin
            mode = MODE_DQ;
          end else if (is_blank(c)) begin
            due(KIND_END, 8'h00, 1'b0);
            mode = MODE_GAP;
          end else if (c == CH_BSL) begin
            esc = 1'b1;
          end else begin
            due(KIND_BYTE, c, 1'b0);
          end
        end
        MODE_SQ: begin
          if (c == CH_SQ) mode = MODE_WORD;
          else due(KIND_BYTE, c, 1'b0);
        end
        default: begin
          if (esc) begin
            esc = 1'b0;
            if (c == CH_DQ || c == CH_BSL) begin
              due(KIND_BYTE, c, 1'b0);
              return 1'b1;
            end
            due(KIND_BYTE, CH_BSL, 1'b0);
          end
          if (c == CH_DQ) mode = MODE_WORD;
          else if (c == CH_BSL) esc = 1'b1;
          else due(KIND_BYTE, c, 1'b0);
        end
      endcase
      return 1'b1;
    endfunction

    function void match_token(input logic [1:0] k, input logic [7:0] c, input logic [4:0] n,
                              input logic lst);
      token_t t;
      if (tokens_due.size() == 0) begin
        fails++;
        $display("%0t: expected no token, got kind=%0d byte=%02h count=%0d last=%0b",
                 $time, k, c, n, lst);
        return;
      end
      t = tokens_due.pop_front();
      matched++;
      if (k !== t.kind || c !== t.ch || n !== t.count || lst !== t.last) begin
        fails++;
        $display("%0t: token mismatch: expected kind=%0d byte=%02h count=%0d last=%0b,",
                 $time, t.kind, t.ch, t.count, t.last);
        $display("%0t:   got kind=%0d byte=%02h count=%0d last=%0b",
                 $time, k, c, n, lst);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  swt_text_if  text_ch();
  swt_token_if token_ch();

  shell_word_tokenizer uut (
    .clk      (clk),
    .rst      (rst),
    .text_ch  (text_ch),
    .token_ch (token_ch)
  );

  always #5 clk = ~clk;

  token_tracker sb = new();
  item_t        line_q[$];
  bit           calm = 1'b0;      // no idling on either side while set
  int unsigned  items_sent = 0;
  int unsigned  items_used = 0;   // items that moved the scanner

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------
  // Line builders: append items to line_q.
  // ---------------------------------------------------------------
  function automatic void put(input logic [7:0] b);
    line_q.push_back(item_t'{text_byte: b, line_done: 1'b0});
  endfunction

  // Close the line; the byte rides along and must be ignored.
  function automatic void end_line();
    line_q.push_back(item_t'{text_byte: 8'($urandom_range(0, 255)), line_done: 1'b1});
  endfunction

  // Ordinary word character: mostly letters, sometimes any byte that is not special.
  function automatic logic [7:0] word_char();
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'h61 + 8'($urandom_range(0, 25));
    end while (b == CH_SPACE || b == CH_TAB || b == CH_NL ||
               b == CH_SQ || b == CH_DQ || b == CH_BSL);
    return b;
  endfunction

  function automatic void put_gap();
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 2))
        0:       put(CH_SPACE);
        1:       put(CH_TAB);
        default: put(CH_NL);
      endcase
    end
  endfunction

  // One well-formed argument made of plain, quoted and escaped pieces.
  function automatic void add_word();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 5))
        3: begin
          put(CH_SQ);
          repeat ($urandom_range(0, 3)) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_SQ);
            put(b);
          end
          put(CH_SQ);
        end
        4: begin
          put(CH_DQ);
          repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 4))
              0: begin put(CH_BSL); put(CH_DQ); end
              1: begin put(CH_BSL); put(CH_BSL); end
              2: begin put(CH_BSL); put(word_char()); end
              default: begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_DQ || b == CH_BSL);
                put(b);
              end
            endcase
          end
          put(CH_DQ);
        end
        5: begin
          put(CH_BSL);
          put(8'($urandom_range(0, 255)));
        end
        default: repeat ($urandom_range(1, 4)) put(word_char());
      endcase
    end
  endfunction

  function automatic void build_line();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      // well-formed line, possibly ending on a lone backslash
      if ($urandom_range(0, 3) == 0) put_gap();
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        if (i != 0) put_gap();
        add_word();
      end
      case ($urandom_range(0, 3))
        0:       put_gap();
        1:       put(CH_BSL);
        default: ;
      endcase
      end_line();
    end else if (r < 76) begin
      // run up to and past the argument limit
      n = $urandom_range(MAX_ARGS - 3, MAX_ARGS + 1);
      for (int i = 0; i < n; i++) begin
        if (i != 0) put(CH_SPACE);
        put(word_char());
      end
      if ($urandom_range(0, 1) == 1) begin
        put_gap();
        add_word();
      end
      end_line();
    end else if (r < 88) begin
      // quote left open at line end
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        add_word();
        if ($urandom_range(0, 2) != 0) put_gap();
      end
      put(($urandom_range(0, 1) == 1) ? CH_SQ : CH_DQ);
      repeat ($urandom_range(0, 3)) put(word_char());
      end_line();
    end else begin
      // raw noise, sometimes followed by an empty line
      repeat ($urandom_range(1, 10)) put(8'($urandom_range(0, 255)));
      end_line();
      if ($urandom_range(0, 1) == 1) end_line();
    end
  endfunction

  // ---------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------
  // Present one item at a falling edge, hold it until the handshake, then note it.
  task automatic send_item(input item_t it);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= it.text_byte;
    text_ch.line_done <= it.line_done;
    do @(posedge clk); while (!text_ch.ready);
    items_sent++;
    if (sb.absorb_item(it.text_byte, it.line_done)) items_used++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(line_q[i]);
    line_q.delete();
  endtask

  // Drop valid and hold off until every due token has come out.
  task automatic drain();
    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Result side: ready toggles at falling edges with random holds.
  initial begin
    int hold;
    hold = 0;
    token_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        token_ch.ready <= 1'b0;
        hold--;
      end else begin
        token_ch.ready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  // Check every token taken at a rising edge.
  always @(posedge clk) begin
    if (!rst && token_ch.valid && token_ch.ready)
      sb.match_token(token_ch.kind, token_ch.out_byte, token_ch.word_count, token_ch.last);
  end

  // Main sequence
  initial begin
    int nlines;
    nlines = 0;
    text_ch.valid     = 1'b0;
    text_ch.text_byte = 8'h00;
    text_ch.line_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero and all-ones bytes, tab and newline separators, an empty
    // quoted argument, and a backslash left hanging at line end.
    put(8'h00); put(8'hff); put(CH_TAB); put(CH_SQ); put(CH_SQ); put(CH_NL);
    put(8'h78); put(CH_BSL); end_line();
    send_line();
    // Double quotes: kept backslash before an ordinary byte, escaped quote,
    // escaped backslash.
    put(CH_DQ); put(CH_BSL); put(8'h71); put(CH_BSL); put(CH_DQ);
    put(CH_BSL); put(CH_BSL); put(CH_DQ); end_line();
    send_line();
    // Unclosed single quote, then an empty line.
    put(CH_SQ); put(8'h61); end_line();
    end_line();
    send_line();
    drain();

    // Random lines until about 400 items have been sent.
    while (items_sent < 400) begin
      calm = ($urandom_range(0, 7) == 0);
      build_line();
      send_line();
      nlines++;
      if (nlines % 25 == 0) drain();
    end
    calm = 1'b0;

    drain();
    // Let any stray token surface before the verdict.
    repeat (8) @(posedge clk);

    $display("Ran %0d lines from %0d items (%0d moved the scanner); %0d tokens checked.",
             sb.lines, items_sent, items_used, sb.matched);
    $display("Saw %0d closed arguments and %0d parse errors; %0d mismatches.",
             sb.args_closed, sb.parse_errs, sb.fails);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("PASS shell_word_tokenizer");
    end else begin
      $display("FAIL shell_word_tokenizer");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("Timed out with %0d tokens still due.", sb.pending());
    $display("FAIL shell_word_tokenizer");
    $finish;
  end

endmodule
